// ===== hdl/assert_macros.svh =====
// Assertion macros for the sorted key/value table RTL.
// Used by files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SKVT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define SKVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SKVT_ASSERT(lbl, prop)
`define SKVT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/skvt_pkg.sv =====
// Shared constants, operation and status codes and the cell control type
// for the sorted key/value table. No dependencies.
`timescale 1ns / 1ps
package skvt_pkg;

  localparam int Depth  = 64;
  localparam int IdxW   = $clog2(Depth);
  localparam int PosW   = IdxW + 1;
  localparam int KeyW   = 32;
  localparam int ValW   = 32;
  localparam int FuncW  = 3;
  localparam int StatW  = 2;

  localparam logic [FuncW-1:0] FUNC_LOWER_BOUND = 3'd0;
  localparam logic [FuncW-1:0] FUNC_INSERT      = 3'd1;
  localparam logic [FuncW-1:0] FUNC_ERASE       = 3'd2;
  localparam logic [FuncW-1:0] FUNC_READ        = 3'd3;
  localparam logic [FuncW-1:0] FUNC_WRITE       = 3'd4;
  localparam logic [FuncW-1:0] FUNC_CLEAR       = 3'd5;

  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_RANGE = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE,
    CELL_WRITE
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic [PosW-1:0]         pos;
    logic signed [KeyW-1:0]  key;
    logic [ValW-1:0]         value;
  } cell_ctrl_t;

endpackage

// ===== hdl/skvt_cell.sv =====
// One entry of the key/value chain: holds a key and a value, shifts to or
// from its neighbors on insert and erase, compares its key. Uses skvt_pkg.
`timescale 1ns / 1ps
module skvt_cell (
  input  logic                            clk_i,
  input  logic [skvt_pkg::PosW-1:0]       idx_i,
  input  skvt_pkg::cell_ctrl_t            ctrl_i,
  input  logic signed [skvt_pkg::KeyW-1:0] prev_key_i,
  input  logic [skvt_pkg::ValW-1:0]       prev_val_i,
  input  logic signed [skvt_pkg::KeyW-1:0] next_key_i,
  input  logic [skvt_pkg::ValW-1:0]       next_val_i,
  output logic signed [skvt_pkg::KeyW-1:0] key_o,
  output logic [skvt_pkg::ValW-1:0]       val_o,
  output logic                            lt_o
);

  logic signed [skvt_pkg::KeyW-1:0] key_q, key_d;
  logic [skvt_pkg::ValW-1:0]        val_q, val_d;

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    case (ctrl_i.op)
      skvt_pkg::CELL_INSERT: begin
        if (idx_i > ctrl_i.pos) begin
          key_d = prev_key_i;
          val_d = prev_val_i;
        end else if (idx_i == ctrl_i.pos) begin
          key_d = ctrl_i.key;
          val_d = ctrl_i.value;
        end
      end
      skvt_pkg::CELL_ERASE: begin
        if (idx_i >= ctrl_i.pos) begin
          key_d = next_key_i;
          val_d = next_val_i;
        end
      end
      skvt_pkg::CELL_WRITE: begin
        if (idx_i == ctrl_i.pos) begin
          val_d = ctrl_i.value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  assign key_o = key_q;
  assign val_o = val_q;
  assign lt_o  = key_q < ctrl_i.key;

endmodule

// ===== hdl/skvt_search.sv =====
// Bisection unit for lower bound: latches the per-cell less-than flags and
// halves the interval one step per cycle. Uses skvt_pkg.
`timescale 1ns / 1ps
module skvt_search (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [skvt_pkg::Depth-1:0]   lt_i,
  input  logic [skvt_pkg::PosW-1:0]    fill_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [skvt_pkg::PosW-1:0]    result_o
);

  logic [skvt_pkg::Depth-1:0] lt_q;
  logic [skvt_pkg::PosW-1:0]  lo_q, hi_q, mid;
  logic                       busy_q;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      lo_q   <= '0;
      hi_q   <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      lo_q   <= '0;
      hi_q   <= fill_i;
    end else if (busy_q) begin
      if (lo_q < hi_q) begin
        if (lt_q[mid[skvt_pkg::IdxW-1:0]]) begin
          lo_q <= mid + 1'b1;
        end else begin
          hi_q <= mid;
        end
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lt_q <= lt_i;
    end
  end

  assign busy_o   = busy_q;
  assign done_o   = busy_q && (lo_q >= hi_q);
  assign result_o = lo_q;

endmodule

// ===== hdl/sorted_key_value_table_core.sv =====
// Sorted key/value table: one transfer in starts an operation; insert and erase
// shift the whole cell chain at the transfer edge. Every operation but lower
// bound goes to the result state at its transfer and loads the output register
// once the output is free. Lower bound latches the per-cell compares at the
// transfer edge, takes one bisection step per cycle (up to log2(depth)+1 = 7
// steps, set by the fill count), then moves to the result state with the found
// position once the interval closes, and loads the output register from there.
// A new transfer is taken as soon as the previous result has moved into the
// output register, even while that result waits. Uses skvt_pkg, skvt_cell,
// skvt_search and assert_macros.svh.
`timescale 1ns / 1ps
module sorted_key_value_table_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [skvt_pkg::PosW-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // position[6:0], search_key[38:7], entry_value[70:39], zero fill
  input  logic [71:0]                       s_axis_tdata_i,
  // func[2:0]
  input  logic [skvt_pkg::FuncW-1:0]        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // found_position[6:0], key_out[38:7], value_out[70:39], entry_count[77:71],
  // zero fill
  output logic [79:0]                       m_axis_tdata_o,
  // status[1:0]
  output logic [skvt_pkg::StatW-1:0]        m_axis_tuser_o
);

  localparam int Depth = skvt_pkg::Depth;
  localparam int PosW  = skvt_pkg::PosW;
  localparam int KeyW  = skvt_pkg::KeyW;
  localparam int ValW  = skvt_pkg::ValW;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0]                     state_q;
  logic [PosW-1:0]                fill_q, cap_q, cap_eff;
  logic [skvt_pkg::FuncW-1:0]     func_q;
  logic [PosW-1:0]                pos_q, found_q;
  logic [skvt_pkg::StatW-1:0]     status_q;

  logic                           in_acc, out_load;
  logic [skvt_pkg::FuncW-1:0]     in_func;
  logic [PosW-1:0]                in_pos;
  logic signed [KeyW-1:0]         in_key;
  logic [ValW-1:0]                in_val;
  logic [skvt_pkg::StatW-1:0]     in_status;
  skvt_pkg::cell_ctrl_t           ctrl;

  logic signed [KeyW-1:0]         cell_key [Depth];
  logic [ValW-1:0]                cell_val [Depth];
  logic [Depth-1:0]               cell_lt;

  logic                           srch_busy, srch_done;
  logic [PosW-1:0]                srch_res;

  logic signed [KeyW-1:0]         rd_key;
  logic [ValW-1:0]                rd_val;
  logic                           rd_ok;

  logic                           m_valid_q;
  logic [79:0]                    m_data_q;
  logic [skvt_pkg::StatW-1:0]     m_user_q;

  assign in_func = s_axis_tuser_i;
  assign in_pos  = s_axis_tdata_i[6:0];
  assign in_key  = s_axis_tdata_i[38:7];
  assign in_val  = s_axis_tdata_i[70:39];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cap_eff         = (cap_q > PosW'(Depth)) ? PosW'(Depth) : cap_q;

  always_comb begin
    in_status = skvt_pkg::STAT_OK;
    case (in_func)
      skvt_pkg::FUNC_INSERT: begin
        if (in_pos > fill_q) begin
          in_status = skvt_pkg::STAT_RANGE;
        end else if (fill_q >= cap_eff) begin
          in_status = skvt_pkg::STAT_FULL;
        end
      end
      skvt_pkg::FUNC_ERASE, skvt_pkg::FUNC_READ, skvt_pkg::FUNC_WRITE: begin
        if (in_pos >= fill_q) begin
          in_status = skvt_pkg::STAT_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl.op    = skvt_pkg::CELL_HOLD;
    ctrl.pos   = in_pos;
    ctrl.key   = in_key;
    ctrl.value = in_val;
    if (in_acc && in_status == skvt_pkg::STAT_OK) begin
      case (in_func)
        skvt_pkg::FUNC_INSERT: ctrl.op = skvt_pkg::CELL_INSERT;
        skvt_pkg::FUNC_ERASE:  ctrl.op = skvt_pkg::CELL_ERASE;
        skvt_pkg::FUNC_WRITE:  ctrl.op = skvt_pkg::CELL_WRITE;
        default:               ctrl.op = skvt_pkg::CELL_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [KeyW-1:0] prev_key, next_key;
    logic [ValW-1:0]        prev_val, next_val;
    if (i == 0) begin : g_first
      assign prev_key = cell_key[i];
      assign prev_val = cell_val[i];
    end else begin : g_mid
      assign prev_key = cell_key[i-1];
      assign prev_val = cell_val[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign next_key = cell_key[i];
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
      assign next_val = cell_val[i+1];
    end
    skvt_cell u_cell (
      .clk_i      (clk_i),
      .idx_i      (PosW'(i)),
      .ctrl_i     (ctrl),
      .prev_key_i (prev_key),
      .prev_val_i (prev_val),
      .next_key_i (next_key),
      .next_val_i (next_val),
      .key_o      (cell_key[i]),
      .val_o      (cell_val[i]),
      .lt_o       (cell_lt[i])
    );
  end

  skvt_search u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc && in_func == skvt_pkg::FUNC_LOWER_BOUND),
    .lt_i     (cell_lt),
    .fill_i   (fill_q),
    .busy_o   (srch_busy),
    .done_o   (srch_done),
    .result_o (srch_res)
  );

  always_comb begin
    rd_key = '0;
    rd_val = '0;
    for (int i = 0; i < Depth; i++) begin
      if (PosW'(i) == pos_q) begin
        rd_key = rd_key | cell_key[i];
        rd_val = rd_val | cell_val[i];
      end
    end
  end

  assign rd_ok    = (func_q == skvt_pkg::FUNC_READ) && (status_q == skvt_pkg::STAT_OK);
  assign out_load = (state_q == ST_RESULT) && (!m_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      cap_q     <= PosW'(Depth);
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= (in_func == skvt_pkg::FUNC_LOWER_BOUND) ? ST_SEARCH : ST_RESULT;
            if (in_func == skvt_pkg::FUNC_CLEAR) begin
              fill_q <= '0;
            end else if (in_status == skvt_pkg::STAT_OK) begin
              if (in_func == skvt_pkg::FUNC_INSERT) begin
                fill_q <= fill_q + 1'b1;
              end else if (in_func == skvt_pkg::FUNC_ERASE) begin
                fill_q <= fill_q - 1'b1;
              end
            end
          end
        end
        ST_SEARCH: begin
          if (srch_done) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q   <= in_func;
      pos_q    <= in_pos;
      status_q <= in_status;
      found_q  <= '0;
    end else if (state_q == ST_SEARCH && srch_done) begin
      found_q <= srch_res;
    end
    if (out_load) begin
      m_user_q <= status_q;
      m_data_q <= {2'b00, fill_q,
                   rd_ok ? rd_val : ValW'(0),
                   rd_ok ? rd_key : KeyW'(0),
                   found_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

`include "assert_macros.svh"

  `SKVT_ASSERT(a_fill_bound, fill_q <= PosW'(Depth))
  `SKVT_ASSERT(a_search_state, !srch_busy || state_q == ST_SEARCH)
  `SKVT_ASSERT_NEXT(a_insert_grows, in_acc && in_func == skvt_pkg::FUNC_INSERT && in_status == skvt_pkg::STAT_OK, fill_q == $past(fill_q) + 1'b1)
  `SKVT_ASSERT_NEXT(a_clear_empties, in_acc && in_func == skvt_pkg::FUNC_CLEAR, fill_q == '0)

endmodule
